// ===== hw/rtl/query_retry_timeout_tracker_macros.svh =====
// Assertion macros for the query retry timeout tracker.
// Included by query_retry_timeout_tracker.sv, which carries concurrent checks; no other dependencies.
`ifndef QUERY_RETRY_TIMEOUT_TRACKER_MACROS_SVH
`define QUERY_RETRY_TIMEOUT_TRACKER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define QRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define QRT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define QRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define QRT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/qrt_pkg.sv =====
// Shared types and constants for the query retry timeout tracker.
// No dependencies.
`timescale 1ns / 1ps

package qrt_pkg;

  localparam logic [15:0] SERVER_PORT = 16'd53;

  // configuration register indexes
  localparam logic [1:0] CFG_SERVER_ADDR = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT     = 2'd1;
  localparam logic [1:0] CFG_RETRY_LIMIT = 2'd2;

  localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
  localparam logic [3:0]  RETRY_RESET   = 4'd3;

  typedef enum logic [1:0] {
    REQ_ISSUE    = 2'd0,
    REQ_RESPONSE = 2'd1,
    REQ_TICK     = 2'd2,
    REQ_ICMP     = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    EV_ISSUED    = 3'd0,
    EV_FULL      = 3'd1,
    EV_DELIVERED = 3'd2,
    EV_IGNORED   = 3'd3,
    EV_RESEND    = 3'd4,
    EV_FAILED    = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] kind;
    logic [31:0] sent_at;
    logic [3:0]  retries;
  } slot_t;

  typedef struct packed {
    event_e      code;
    logic [15:0] id;
    logic [15:0] kind;
    logic [3:0]  retries;
  } res_t;

endpackage

// ===== hw/rtl/qrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module qrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/query_retry_timeout_tracker.sv =====
// Query retry timeout tracker: pending name queries in a slot RAM (qrt_pkg, qrt_ram, macros).
// A walked item holds busy while every slot is read and processed, then through a drain step and
// the finish state; a new item is accepted only when busy is low. A response or ICMP error that
// needs no walk goes straight to the finish state. Results: at most one per cycle, never
// stalled; the last one appears in the same cycle as busy drops.
// Reset (async, active low) empties the table, zeroes the id counter and loads config defaults.
`timescale 1ns / 1ps
`include "query_retry_timeout_tracker_macros.svh"

module query_retry_timeout_tracker #(
  parameter int SLOT_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] now_time_i,
  input  logic [15:0] record_kind_i,
  input  logic [15:0] reply_id_i,
  input  logic        parse_ok_i,
  input  logic [31:0] peer_address_i,
  input  logic [15:0] peer_port_i,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // results
  output logic        result_valid_o,
  output logic [2:0]  event_code_o,
  output logic [15:0] query_id_o,
  output logic [15:0] query_kind_o,
  output logic [3:0]  retry_count_o,
  output logic        last_result_o
);

  import qrt_pkg::*;

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);
  localparam int SLOT_W = $bits(slot_t);

  // configuration
  logic [31:0] server_q;
  logic [15:0] timeout_q;
  logic [3:0]  limit_q;

  // control
  state_e state_q, state_d;
  logic [IW-1:0] rd_idx_q, rd_idx_d;
  logic rd_done_q, rd_done_d;
  logic p_vld_q, p_vld_d;
  logic [IW-1:0] p_idx_q, p_idx_d;
  logic [SLOT_COUNT-1:0] valid_q, valid_d;
  logic [15:0] next_id_q, next_id_d;

  // per-walk search state
  logic match_fnd_q, match_fnd_d;
  logic [IW-1:0] match_idx_q, match_idx_d;
  logic free_fnd_q, free_fnd_d;
  logic [IW-1:0] free_idx_q, free_idx_d;
  logic hit_fnd_q, hit_fnd_d;

  // captured transaction
  req_e        op_q;
  logic [31:0] op_now_q;
  logic [15:0] op_kind_q;
  logic [15:0] op_rid_q;
  logic        op_srv_q;

  // one-deep hold so the final result of a walk can be flagged last
  logic hold_vld_q, hold_vld_d;
  res_t hold_q, hold_d;

  // output register
  logic out_vld_q, out_vld_d;
  res_t out_q, out_d;
  logic out_last_q, out_last_d;

  // RAM port
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  slot_t         ram_wdata, rd_slot;
  logic [SLOT_W-1:0] ram_rdata;

  // datapath helpers
  logic        accept;
  logic        from_srv;
  logic        need_walk;
  logic        slot_v;
  logic [31:0] age;
  logic        new_vld;
  res_t        new_res;
  logic        fin_vld;
  res_t        fin_res;
  logic [IW-1:0] pick;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign from_srv  = (peer_address_i == server_q) && (peer_port_i == SERVER_PORT);
  assign rd_slot   = slot_t'(ram_rdata);
  assign slot_v    = valid_q[p_idx_q];
  assign age       = op_now_q - rd_slot.sent_at;
  assign pick      = match_fnd_q ? match_idx_q : free_idx_q;

  always_comb begin
    case (req_e'(req_type_i))
      REQ_ISSUE:    need_walk = 1'b1;
      REQ_RESPONSE: need_walk = from_srv && parse_ok_i;
      REQ_TICK:     need_walk = 1'b1;
      REQ_ICMP:     need_walk = from_srv;
      default:      need_walk = 1'b1;
    endcase
  end

  qrt_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(SLOT_COUNT)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Walk: read slot k while slot k-1's data is processed. A write-back only
  // targets the slot under processing, never the one being read, so the two
  // never collide within a walk; items are serialized, so none across walks.
  always_comb begin
    state_d     = state_q;
    rd_idx_d    = rd_idx_q;
    rd_done_d   = rd_done_q;
    p_vld_d     = 1'b0;
    p_idx_d     = rd_idx_q;
    valid_d     = valid_q;
    next_id_d   = next_id_q;
    match_fnd_d = match_fnd_q;
    match_idx_d = match_idx_q;
    free_fnd_d  = free_fnd_q;
    free_idx_d  = free_idx_q;
    hit_fnd_d   = hit_fnd_q;
    hold_vld_d  = hold_vld_q;
    hold_d      = hold_q;
    out_vld_d   = 1'b0;
    out_d       = out_q;
    out_last_d  = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = rd_idx_q;
    ram_we      = 1'b0;
    ram_waddr   = p_idx_q;
    ram_wdata   = rd_slot;
    new_vld     = 1'b0;
    new_res     = '{code: EV_IGNORED, id: '0, kind: '0, retries: '0};
    fin_vld     = 1'b0;
    fin_res     = '{code: EV_IGNORED, id: '0, kind: '0, retries: '0};

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rd_idx_d    = '0;
          rd_done_d   = 1'b0;
          match_fnd_d = 1'b0;
          free_fnd_d  = 1'b0;
          hit_fnd_d   = 1'b0;
          state_d     = need_walk ? ST_WALK : ST_FINISH;
        end
      end

      ST_WALK: begin
        if (!rd_done_q) begin
          ram_re   = 1'b1;
          p_vld_d  = 1'b1;
          rd_idx_d = rd_idx_q + IW'(1);
          if (rd_idx_q == LAST_IDX) begin
            rd_done_d = 1'b1;
          end
        end

        if (p_vld_q) begin
          case (op_q)
            REQ_ISSUE: begin
              // an entry still pending under the next id wins over a free slot
              if (slot_v && (rd_slot.id == next_id_q) && !match_fnd_q) begin
                match_fnd_d = 1'b1;
                match_idx_d = p_idx_q;
              end
              if (!slot_v && !free_fnd_q) begin
                free_fnd_d = 1'b1;
                free_idx_d = p_idx_q;
              end
            end
            REQ_RESPONSE: begin
              if (slot_v && (rd_slot.id == op_rid_q) && !hit_fnd_q) begin
                hit_fnd_d        = 1'b1;
                valid_d[p_idx_q] = 1'b0;
                new_vld          = 1'b1;
                new_res          = '{code: EV_DELIVERED, id: rd_slot.id,
                                     kind: rd_slot.kind, retries: rd_slot.retries};
              end
            end
            REQ_TICK: begin
              if (slot_v && (age > {16'd0, timeout_q})) begin
                new_vld = 1'b1;
                if (rd_slot.retries >= limit_q) begin
                  valid_d[p_idx_q] = 1'b0;
                  new_res = '{code: EV_FAILED, id: rd_slot.id,
                              kind: rd_slot.kind, retries: rd_slot.retries};
                end else begin
                  ram_we            = 1'b1;
                  ram_wdata.sent_at = op_now_q;
                  ram_wdata.retries = rd_slot.retries + 4'd1;
                  new_res = '{code: EV_RESEND, id: rd_slot.id,
                              kind: rd_slot.kind, retries: rd_slot.retries + 4'd1};
                end
              end
            end
            REQ_ICMP: begin
              if (slot_v) begin
                valid_d[p_idx_q] = 1'b0;
                new_vld          = 1'b1;
                new_res          = '{code: EV_FAILED, id: rd_slot.id,
                                     kind: rd_slot.kind, retries: rd_slot.retries};
              end
            end
            default: ;
          endcase
        end

        // a new result pushes the held one out, not marked last
        if (new_vld) begin
          if (hold_vld_q) begin
            out_vld_d = 1'b1;
            out_d     = hold_q;
          end
          hold_vld_d = 1'b1;
          hold_d     = new_res;
        end

        if (rd_done_q && !p_vld_q) begin
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        case (op_q)
          REQ_ISSUE: begin
            fin_vld = 1'b1;
            if (match_fnd_q || free_fnd_q) begin
              ram_we        = 1'b1;
              ram_waddr     = pick;
              ram_wdata     = '{id: next_id_q, kind: op_kind_q,
                                sent_at: op_now_q, retries: '0};
              valid_d[pick] = 1'b1;
              next_id_d     = next_id_q + 16'd1;
              fin_res = '{code: EV_ISSUED, id: next_id_q, kind: op_kind_q, retries: '0};
            end else begin
              fin_res = '{code: EV_FULL, id: next_id_q, kind: op_kind_q, retries: '0};
            end
          end
          REQ_RESPONSE: begin
            if (!hit_fnd_q) begin
              fin_vld = 1'b1;
              fin_res = '{code: EV_IGNORED, id: op_rid_q, kind: '0, retries: '0};
            end
          end
          REQ_ICMP: begin
            // error from anyone else: one ignored result, table untouched
            if (!op_srv_q) begin
              fin_vld = 1'b1;
            end
          end
          REQ_TICK: ;
          default: ;
        endcase

        if (fin_vld) begin
          out_vld_d  = 1'b1;
          out_d      = fin_res;
          out_last_d = 1'b1;
        end else if (hold_vld_q) begin
          out_vld_d  = 1'b1;
          out_d      = hold_q;
          out_last_d = 1'b1;
        end
        hold_vld_d = 1'b0;
        state_d    = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_idx_q    <= '0;
      rd_done_q   <= 1'b0;
      p_vld_q     <= 1'b0;
      valid_q     <= '0;
      next_id_q   <= '0;
      match_fnd_q <= 1'b0;
      free_fnd_q  <= 1'b0;
      hit_fnd_q   <= 1'b0;
      hold_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
      server_q    <= '0;
      timeout_q   <= TIMEOUT_RESET;
      limit_q     <= RETRY_RESET;
    end else begin
      state_q     <= state_d;
      rd_idx_q    <= rd_idx_d;
      rd_done_q   <= rd_done_d;
      p_vld_q     <= p_vld_d;
      valid_q     <= valid_d;
      next_id_q   <= next_id_d;
      match_fnd_q <= match_fnd_d;
      free_fnd_q  <= free_fnd_d;
      hit_fnd_q   <= hit_fnd_d;
      hold_vld_q  <= hold_vld_d;
      out_vld_q   <= out_vld_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SERVER_ADDR: server_q  <= cfg_data_i;
          CFG_TIMEOUT:     timeout_q <= cfg_data_i[15:0];
          CFG_RETRY_LIMIT: limit_q   <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    p_idx_q     <= p_idx_d;
    match_idx_q <= match_idx_d;
    free_idx_q  <= free_idx_d;
    hold_q      <= hold_d;
    out_q       <= out_d;
    out_last_q  <= out_last_d;
    if (accept) begin
      op_q      <= req_e'(req_type_i);
      op_now_q  <= now_time_i;
      op_kind_q <= record_kind_i;
      op_rid_q  <= reply_id_i;
      op_srv_q  <= from_srv;
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = out_vld_q;
  assign event_code_o   = out_q.code;
  assign query_id_o     = out_q.id;
  assign query_kind_o   = out_q.kind;
  assign retry_count_o  = out_q.retries;
  assign last_result_o  = out_last_q;

  `QRT_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o,
                  "accept did not raise busy")
  `QRT_ASSERT_IMP(a_last_after_finish, clk_i, rst_ni, out_vld_q && out_last_q,
                  $past(state_q) == ST_FINISH, "last result outside finish")
  `QRT_ASSERT_IMP(a_hold_empty_idle, clk_i, rst_ni, state_q == ST_IDLE, !hold_vld_q,
                  "held result left over when idle")
  `QRT_ASSERT_IMP(a_no_rw_collision, clk_i, rst_ni, ram_we && ram_re, ram_waddr != ram_raddr,
                  "slot write and read collide")

endmodule
